// File: rtl/core/mss_pkg.sv
// shared types, constants and codes of the multichannel step sequencer
package mss_pkg;

   localparam int IO_CHANNELS       = 3;
   localparam int DEFAULT_CHANNELS  = 3;
   localparam int DEFAULT_MAX_STEPS = 16;

   localparam int STEP_W      = 4;
   localparam int STEPS_CFG_W = 5;
   localparam int CNT_W       = 8;
   localparam int RND_W       = 8;
   localparam int OP_W        = 4;
   localparam int MASK_W      = 3;
   localparam int RSEL_W      = 6;
   localparam int CSR_IDX_W   = 4;
   localparam int CSR_DATA_W  = 8;
   localparam int ITER_W      = $clog2(RND_W);

   localparam logic [STEPS_CFG_W-1:0] STEPS_RESET  = 5'd16;
   localparam logic [CNT_W-1:0]       DIVIDE_RESET = 8'd1;
   localparam logic [MASK_W-1:0]      RMODE_RESET  = 3'd0;
   localparam logic [RSEL_W-1:0]      RSEL_RESET   = 6'd48;
   localparam logic [1:0]             RST_OFF      = 2'd3;
   localparam logic [STEP_W-1:0]      STEP_MASK    = 4'hf;

   localparam logic [CSR_IDX_W-1:0] CSR_STEPS_A  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEPS_B  = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEPS_C  = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIVIDE_A = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DIVIDE_B = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DIVIDE_C = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_RMODE    = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_RSEL     = 4'd7;

   typedef enum logic [OP_W-1:0] {
      OP_CLOCK      = 4'd0,
      OP_RESET_EDGE = 4'd1,
      OP_RUN        = 4'd2,
      OP_STOP       = 4'd3,
      OP_RESET_CMD  = 4'd4,
      OP_FORWARD    = 4'd5,
      OP_REVERSE    = 4'd6,
      OP_CLAMP      = 4'd7,
      OP_INIT       = 4'd8
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [STEPS_CFG_W-1:0] steps;
      logic [CNT_W-1:0]       divide;
      logic                   random_mode;
   } lane_cfg_type;

   typedef struct packed {
      logic   start;
      op_type op;
      logic   running;
      logic   shift;
      logic   commit;
   } lane_ctrl_type;

endpackage

// File: rtl/core/mss_lane.sv
// one sequencer channel: divider count, step register and serial modulo unit
module mss_lane
   import mss_pkg::*;
#(
   parameter int MAX_STEPS = DEFAULT_MAX_STEPS
) (
   input  logic                clock,
   input  logic                reset,
   input  lane_ctrl_type       ctrl,
   input  lane_cfg_type        cfg,
   input  logic [RND_W-1:0]    random_byte,
   output logic [STEP_W-1:0]   step,
   output logic                trig
);

   logic [STEP_W-1:0]      step_ff, step_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   trig_ff, trig_in;
   logic                   use_mod_ff, use_mod_in;
   logic [STEP_W-1:0]      rem_ff, rem_in;
   logic [RND_W-1:0]       dvd_ff, dvd_in;

   logic [STEPS_CFG_W-1:0] s_eff;
   logic [STEPS_CFG_W-1:0] s_last;
   logic [STEPS_CFG_W-1:0] step_inc;
   logic [CNT_W-1:0]       count_inc;
   logic [STEP_W:0]        trial;

   always_comb begin
      if (cfg.steps == '0) begin
         s_eff = STEPS_CFG_W'(1);
      end else if (cfg.steps > STEPS_CFG_W'(MAX_STEPS)) begin
         s_eff = STEPS_CFG_W'(MAX_STEPS);
      end else begin
         s_eff = cfg.steps;
      end
      s_last    = s_eff - STEPS_CFG_W'(1);
      step_inc  = {1'b0, step_ff} + STEPS_CFG_W'(1);
      count_inc = count_ff + CNT_W'(1);
      trial     = {rem_ff, dvd_ff[RND_W-1]};
   end

   always_comb begin
      step_in    = step_ff;
      count_in   = count_ff;
      trig_in    = trig_ff;
      use_mod_in = use_mod_ff;
      rem_in     = rem_ff;
      dvd_in     = dvd_ff;
      if (ctrl.start) begin
         trig_in    = 1'b0;
         use_mod_in = 1'b0;
         rem_in     = '0;
         case (ctrl.op)
            OP_CLOCK: begin
               if (ctrl.running) begin
                  if (count_inc == cfg.divide) begin
                     count_in   = '0;
                     trig_in    = 1'b1;
                     use_mod_in = 1'b1;
                     dvd_in     = cfg.random_mode ? random_byte : RND_W'(step_inc);
                  end else begin
                     count_in = count_inc;
                  end
               end
            end
            OP_FORWARD: begin
               use_mod_in = 1'b1;
               dvd_in     = RND_W'(step_inc);
            end
            OP_RESET_EDGE, OP_RESET_CMD, OP_INIT: begin
               step_in  = '0;
               count_in = '0;
            end
            OP_REVERSE: begin
               step_in = (step_ff != '0) ? step_ff - STEP_W'(1) : s_last[STEP_W-1:0];
            end
            OP_CLAMP: begin
               if ({1'b0, step_ff} >= s_eff) begin
                  step_in = s_last[STEP_W-1:0];
               end
            end
            default: begin
            end
         endcase
      end else if (ctrl.shift) begin
         // restoring remainder, one dividend bit per cycle
         rem_in = (trial >= s_eff) ? STEP_W'(trial - s_eff) : trial[STEP_W-1:0];
         dvd_in = {dvd_ff[RND_W-2:0], 1'b0};
      end
      if (ctrl.commit && use_mod_ff) begin
         step_in = rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff    <= '0;
         count_ff   <= '0;
         trig_ff    <= 1'b0;
         use_mod_ff <= 1'b0;
      end else begin
         step_ff    <= step_in;
         count_ff   <= count_in;
         trig_ff    <= trig_in;
         use_mod_ff <= use_mod_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
   end

   assign step = step_ff;
   assign trig = trig_ff;

endmodule

// File: rtl/core/mss_merge.sv
// merges lane steps and triggers into the result fields and reset output match
module mss_merge
   import mss_pkg::*;
#(
   parameter int CHANNELS = DEFAULT_CHANNELS
) (
   input  logic [CHANNELS-1:0][STEP_W-1:0] steps,
   input  logic [CHANNELS-1:0]             trigs,
   input  logic [RSEL_W-1:0]               rsel,
   output logic [STEP_W-1:0]               step_a,
   output logic [STEP_W-1:0]               step_b,
   output logic [STEP_W-1:0]               step_c,
   output logic [MASK_W-1:0]               trig_mask,
   output logic                            rst_match
);

   logic [1:0] sel_ch;

   assign sel_ch = rsel[RSEL_W-1:STEP_W];

   always_comb begin
      rst_match = 1'b0;
      trig_mask = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         if (i < IO_CHANNELS) begin
            trig_mask[i % MASK_W] = trigs[i];
            if (sel_ch != RST_OFF && sel_ch == 2'(i)
                && steps[i] == (rsel[STEP_W-1:0] & STEP_MASK)) begin
               rst_match = 1'b1;
            end
         end
      end
   end

   assign step_a = steps[0] & STEP_MASK;

   if (CHANNELS > 1) begin : g_b
      assign step_b = steps[1] & STEP_MASK;
   end else begin : g_no_b
      assign step_b = '0;
   end

   if (CHANNELS > 2) begin : g_c
      assign step_c = steps[2] & STEP_MASK;
   end else begin : g_no_c
      assign step_c = '0;
   end

endmodule

// File: rtl/core/multichannel_step_sequencer.sv
// top level of the multichannel step sequencer: control, registers, lanes, result
//
//   port group   direction   handshake            payload
//   req_         in          req_valid/req_ready  operation, random_a..c
//   rsp_         out         rsp_valid/rsp_ready  step_out_a..c, trigger_mask, reset_out,
//                                                 advanced, running
//   csr_         in          csr_write            csr_index, csr_wdata
//
// every beat goes through accept, the bit-serial modulo in each lane (one random
// byte bit per cycle), then the merge into the result register
// one beat at a time; the next beat is taken while the previous result waits
// a stalled rsp_ready holds the finished result in the merge cycle
// synchronous reset clears steps, counts and run state and sets the CSRs to their reset values
module multichannel_step_sequencer
   import mss_pkg::*;
#(
   parameter int CHANNELS  = DEFAULT_CHANNELS,
   parameter int MAX_STEPS = DEFAULT_MAX_STEPS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [OP_W-1:0]       req_operation,
   input  logic [RND_W-1:0]      req_random_a,
   input  logic [RND_W-1:0]      req_random_b,
   input  logic [RND_W-1:0]      req_random_c,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [STEP_W-1:0]     rsp_step_out_a,
   output logic [STEP_W-1:0]     rsp_step_out_b,
   output logic [STEP_W-1:0]     rsp_step_out_c,
   output logic [MASK_W-1:0]     rsp_trigger_mask,
   output logic                  rsp_reset_out,
   output logic                  rsp_advanced,
   output logic                  rsp_running,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   state_type                         state_ff, state_in;
   logic [ITER_W-1:0]                 iter_ff, iter_in;
   op_type                            op_ff, op_in;
   logic                              run_ff, run_in;
   logic                              adv_ff, adv_in;

   logic [IO_CHANNELS-1:0][STEPS_CFG_W-1:0] steps_cfg_ff;
   logic [IO_CHANNELS-1:0][CNT_W-1:0]       divide_cfg_ff;
   logic [MASK_W-1:0]                       rmode_ff;
   logic [RSEL_W-1:0]                       rsel_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STEP_W-1:0]     step_a_ff, step_b_ff, step_c_ff;
   logic [MASK_W-1:0]     trig_mask_ff;
   logic                  rst_out_ff, adv_out_ff, run_out_ff;

   logic                  accept;
   logic                  load;
   lane_ctrl_type         ctrl;

   logic [CHANNELS-1:0][STEP_W-1:0] lane_steps;
   logic [CHANNELS-1:0]             lane_trigs;
   logic [STEP_W-1:0]               m_step_a, m_step_b, m_step_c;
   logic [MASK_W-1:0]               m_trig_mask;
   logic                            m_rst;

   assign accept = req_valid && req_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      iter_in  = iter_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_CALC;
               iter_in  = '0;
            end
         end
         ST_CALC: begin
            iter_in = iter_ff + ITER_W'(1);
            if (iter_ff == ITER_W'(RND_W - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs of the control
   always_comb begin
      req_ready    = 1'b0;
      load         = 1'b0;
      ctrl.shift   = 1'b0;
      ctrl.commit  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_CALC: begin
            ctrl.shift  = 1'b1;
            ctrl.commit = (iter_ff == ITER_W'(RND_W - 1));
         end
         ST_FINISH: begin
            load = !rsp_valid_ff || rsp_ready;
         end
         default: begin
         end
      endcase
      ctrl.start   = accept;
      ctrl.op      = op_type'(req_operation);
      ctrl.running = run_ff;
   end

   always_comb begin
      op_in  = op_ff;
      run_in = run_ff;
      adv_in = adv_ff;
      if (accept) begin
         op_in  = op_type'(req_operation);
         adv_in = 1'b0;
         case (op_type'(req_operation))
            OP_CLOCK: adv_in = run_ff;
            OP_RUN:   run_in = 1'b1;
            OP_STOP:  run_in = 1'b0;
            OP_INIT:  run_in = 1'b0;
            default: begin
            end
         endcase
      end
      rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         iter_ff       <= '0;
         op_ff         <= OP_CLOCK;
         run_ff        <= 1'b0;
         adv_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         steps_cfg_ff  <= {IO_CHANNELS{STEPS_RESET}};
         divide_cfg_ff <= {IO_CHANNELS{DIVIDE_RESET}};
         rmode_ff      <= RMODE_RESET;
         rsel_ff       <= RSEL_RESET;
      end else begin
         state_ff     <= state_in;
         iter_ff      <= iter_in;
         op_ff        <= op_in;
         run_ff       <= run_in;
         adv_ff       <= adv_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            case (csr_index)
               CSR_STEPS_A:  steps_cfg_ff[0]  <= csr_wdata[STEPS_CFG_W-1:0];
               CSR_STEPS_B:  steps_cfg_ff[1]  <= csr_wdata[STEPS_CFG_W-1:0];
               CSR_STEPS_C:  steps_cfg_ff[2]  <= csr_wdata[STEPS_CFG_W-1:0];
               CSR_DIVIDE_A: divide_cfg_ff[0] <= csr_wdata[CNT_W-1:0];
               CSR_DIVIDE_B: divide_cfg_ff[1] <= csr_wdata[CNT_W-1:0];
               CSR_DIVIDE_C: divide_cfg_ff[2] <= csr_wdata[CNT_W-1:0];
               CSR_RMODE:    rmode_ff         <= csr_wdata[MASK_W-1:0];
               CSR_RSEL:     rsel_ff          <= csr_wdata[RSEL_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
      lane_cfg_type     cfg;
      logic [RND_W-1:0] rnd;

      if (i == 0) begin : g_io
         assign cfg = '{steps: steps_cfg_ff[0], divide: divide_cfg_ff[0],
                        random_mode: rmode_ff[0]};
         assign rnd = req_random_a;
      end else if (i == 1) begin : g_io
         assign cfg = '{steps: steps_cfg_ff[1], divide: divide_cfg_ff[1],
                        random_mode: rmode_ff[1]};
         assign rnd = req_random_b;
      end else if (i == 2) begin : g_io
         assign cfg = '{steps: steps_cfg_ff[2], divide: divide_cfg_ff[2],
                        random_mode: rmode_ff[2]};
         assign rnd = req_random_c;
      end else begin : g_io
         // channels without ports keep their reset setup
         assign cfg = '{steps: STEPS_RESET, divide: DIVIDE_RESET, random_mode: 1'b0};
         assign rnd = '0;
      end

      mss_lane #(
         .MAX_STEPS(MAX_STEPS)
      ) u_lane (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .cfg         (cfg),
         .random_byte (rnd),
         .step        (lane_steps[i]),
         .trig        (lane_trigs[i])
      );
   end

   mss_merge #(
      .CHANNELS(CHANNELS)
   ) u_merge (
      .steps     (lane_steps),
      .trigs     (lane_trigs),
      .rsel      (rsel_ff),
      .step_a    (m_step_a),
      .step_b    (m_step_b),
      .step_c    (m_step_c),
      .trig_mask (m_trig_mask),
      .rst_match (m_rst)
   );

   always_ff @(posedge clock) begin
      if (load) begin
         step_a_ff    <= m_step_a;
         step_b_ff    <= m_step_b;
         step_c_ff    <= m_step_c;
         trig_mask_ff <= (op_ff == OP_CLOCK) ? m_trig_mask : '0;
         rst_out_ff   <= m_rst;
         adv_out_ff   <= adv_ff;
         run_out_ff   <= run_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_step_out_a   = step_a_ff;
   assign rsp_step_out_b   = step_b_ff;
   assign rsp_step_out_c   = step_c_ff;
   assign rsp_trigger_mask = trig_mask_ff;
   assign rsp_reset_out    = rst_out_ff;
   assign rsp_advanced     = adv_out_ff;
   assign rsp_running      = run_out_ff;

endmodule
